// ----- src/ifs_pkg.sv -----
// ----------------------------------------------------------------------------
// ifs_pkg: shared types, constants and the step table of the flux stencil
// Cell and result types, control bundles between controller and datapath,
// and the sequence of multiply-accumulate steps that forms one flux integral.
// ----------------------------------------------------------------------------
package ifs_pkg;

  // Grid and number format
  localparam int MAX_COLUMNS = 256;
  localparam int FRAC_BITS   = 16;
  localparam int COL_W       = $clog2(MAX_COLUMNS);
  localparam int CW          = $clog2(MAX_COLUMNS + 1);

  // Configuration port
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  // Serial multiplier widths: magnitudes up to 2^61 times up to 2^32
  localparam int MA_W = 62;
  localparam int MB_W = 33;
  localparam int PW   = 96;

  localparam logic signed [63:0] LIM = 64'sh2000_0000_0000_0000;

  // Step sequencing
  localparam int STEP_W    = 5;
  localparam int LAST_STEP = 21;

  typedef struct packed {
    logic signed [31:0] p;
    logic signed [31:0] u;
    logic signed [31:0] v;
  } cell_t;

  typedef struct packed {
    logic signed [31:0] flux_mass;
    logic signed [31:0] flux_x_momentum;
    logic signed [31:0] flux_y_momentum;
    logic [7:0]         cell_column;
    logic [15:0]        cell_row;
    logic               last_cell;
  } res_t;

  typedef struct packed {
    logic [8:0]  grid_columns;
    logic [15:0] grid_rows;
    logic [30:0] inv_two_beta;
    logic [30:0] inv_re_dx;
    logic [30:0] inv_re_dy;
    logic [30:0] inv_dx;
    logic [30:0] inv_dy;
  } cfg_t;

  // Operand sources of the multiplier
  typedef enum logic [4:0] {
    OP_DUEW, OP_DVNS, OP_SUE, OP_SUW, OP_SVE, OP_SVW, OP_SUN, OP_SUS,
    OP_SVN, OP_SVS, OP_DPEW, OP_DPNS, OP_LUX, OP_LVX, OP_LUY, OP_LVY,
    OP_DFM, OP_DGM, OP_DFX, OP_DFY, OP_DGX, OP_DGY,
    OP_I2B, OP_IRX, OP_IRY, OP_IDX, OP_IDY, OP_ONE
  } opnd_t;

  localparam int OP_COUNT = 28;

  // Right shift applied to a product
  typedef enum logic [1:0] {SH_ONE, SH_F, SH_F2} sh_t;

  // Where a finished sum goes
  typedef enum logic [3:0] {
    D_DFM, D_DGM, D_DFX, D_DFY, D_DGX, D_DGY, D_FM, D_FX, D_FY
  } dest_t;

  typedef struct packed {
    opnd_t a;
    opnd_t b;
    sh_t   sh;
    logic  sub;
    logic  first;
    logic  last;
    dest_t dest;
  } step_t;

  // Controller to datapath
  typedef struct packed {
    logic              take;
    logic              rd0;
    logic              rd1;
    logic              win;
    logic              setup;
    logic              run;
    logic              rnd;
    logic              acc;
    logic              emit;
    logic [STEP_W-1:0] step;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic interior;
    logic mul_done;
  } sts_t;

  function automatic step_t mk(opnd_t a, opnd_t b, sh_t sh, logic sub,
                               logic first, logic last, dest_t dest);
    step_t s;
    s.a = a; s.b = b; s.sh = sh; s.sub = sub;
    s.first = first; s.last = last; s.dest = dest;
    return s;
  endfunction

  // One flux integral as a fixed sequence of multiply-accumulate steps
  function automatic step_t step_info(logic [STEP_W-1:0] idx);
    step_t s;
    s = mk(OP_DUEW, OP_I2B, SH_F, 1'b0, 1'b1, 1'b1, D_DFM);
    case (idx)
      5'd0:  s = mk(OP_DUEW, OP_I2B, SH_F,   1'b0, 1'b1, 1'b1, D_DFM);
      5'd1:  s = mk(OP_DVNS, OP_I2B, SH_F,   1'b0, 1'b1, 1'b1, D_DGM);
      5'd2:  s = mk(OP_SUE,  OP_SUE, SH_F2,  1'b0, 1'b1, 1'b0, D_DFX);
      5'd3:  s = mk(OP_SUW,  OP_SUW, SH_F2,  1'b1, 1'b0, 1'b0, D_DFX);
      5'd4:  s = mk(OP_DPEW, OP_ONE, SH_ONE, 1'b0, 1'b0, 1'b0, D_DFX);
      5'd5:  s = mk(OP_LUX,  OP_IRX, SH_F,   1'b1, 1'b0, 1'b1, D_DFX);
      5'd6:  s = mk(OP_SUE,  OP_SVE, SH_F2,  1'b0, 1'b1, 1'b0, D_DFY);
      5'd7:  s = mk(OP_SUW,  OP_SVW, SH_F2,  1'b1, 1'b0, 1'b0, D_DFY);
      5'd8:  s = mk(OP_LVX,  OP_IRX, SH_F,   1'b1, 1'b0, 1'b1, D_DFY);
      5'd9:  s = mk(OP_SUN,  OP_SVN, SH_F2,  1'b0, 1'b1, 1'b0, D_DGX);
      5'd10: s = mk(OP_SUS,  OP_SVS, SH_F2,  1'b1, 1'b0, 1'b0, D_DGX);
      5'd11: s = mk(OP_LUY,  OP_IRY, SH_F,   1'b1, 1'b0, 1'b1, D_DGX);
      5'd12: s = mk(OP_SVN,  OP_SVN, SH_F2,  1'b0, 1'b1, 1'b0, D_DGY);
      5'd13: s = mk(OP_SVS,  OP_SVS, SH_F2,  1'b1, 1'b0, 1'b0, D_DGY);
      5'd14: s = mk(OP_DPNS, OP_ONE, SH_ONE, 1'b0, 1'b0, 1'b0, D_DGY);
      5'd15: s = mk(OP_LVY,  OP_IRY, SH_F,   1'b1, 1'b0, 1'b1, D_DGY);
      5'd16: s = mk(OP_DFM,  OP_IDX, SH_F,   1'b1, 1'b1, 1'b0, D_FM);
      5'd17: s = mk(OP_DGM,  OP_IDY, SH_F,   1'b1, 1'b0, 1'b1, D_FM);
      5'd18: s = mk(OP_DFX,  OP_IDX, SH_F,   1'b1, 1'b1, 1'b0, D_FX);
      5'd19: s = mk(OP_DGX,  OP_IDY, SH_F,   1'b1, 1'b0, 1'b1, D_FX);
      5'd20: s = mk(OP_DFY,  OP_IDX, SH_F,   1'b1, 1'b1, 1'b0, D_FY);
      5'd21: s = mk(OP_DGY,  OP_IDY, SH_F,   1'b1, 1'b0, 1'b1, D_FY);
      default: s = mk(OP_DUEW, OP_I2B, SH_F, 1'b0, 1'b1, 1'b1, D_DFM);
    endcase
    return s;
  endfunction

  function automatic logic signed [63:0] ext(logic signed [31:0] x);
    return {{32{x[31]}}, x};
  endfunction

  // Saturating clamp of a sum to +-2^61
  function automatic logic signed [63:0] sat61(logic signed [63:0] s);
    if (s > LIM) return LIM;
    if (s < -LIM) return -LIM;
    return s;
  endfunction

  // Clamp to the signed 32-bit range
  function automatic logic signed [31:0] out32(logic signed [63:0] x);
    if (x > 64'sh0000_0000_7FFF_FFFF) return 32'sh7FFF_FFFF;
    if (x < -64'sh0000_0000_8000_0000) return 32'sh8000_0000;
    return x[31:0];
  endfunction

endpackage

// ----- src/ifs_if.sv -----
// ----------------------------------------------------------------------------
// ifs_in_if / ifs_out_if: cell and result channels
// Valid/ready channels; a transfer happens when valid and ready are high.
// ----------------------------------------------------------------------------
interface ifs_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pressure;
  logic signed [31:0] u_velocity;
  logic signed [31:0] v_velocity;

  modport source(output valid, pressure, u_velocity, v_velocity, input ready);
  modport sink(input valid, pressure, u_velocity, v_velocity, output ready);
endinterface

interface ifs_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] flux_mass;
  logic signed [31:0] flux_x_momentum;
  logic signed [31:0] flux_y_momentum;
  logic [7:0]         cell_column;
  logic [15:0]        cell_row;
  logic               last_cell;

  modport source(output valid, flux_mass, flux_x_momentum, flux_y_momentum,
                 cell_column, cell_row, last_cell, input ready);
  modport sink(input valid, flux_mass, flux_x_momentum, flux_y_momentum,
               cell_column, cell_row, last_cell, output ready);
endinterface

// ----- src/ifs_cfg.sv -----
// ----------------------------------------------------------------------------
// ifs_cfg: configuration registers
// APB-style register file; a write to a grid size register restarts the frame.
// ----------------------------------------------------------------------------
module ifs_cfg (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ifs_pkg::ADDR_W-1:0]   paddr,
  input  logic [ifs_pkg::DATA_W-1:0]   pwdata,
  output logic [ifs_pkg::DATA_W-1:0]   prdata,
  output logic                         pready,
  output ifs_pkg::cfg_t                cfg,
  output logic                         restart
);

  typedef enum logic [2:0] {
    REG_COLS, REG_ROWS, REG_I2B, REG_IRX, REG_IRY, REG_IDX, REG_IDY, REG_NONE
  } reg_idx_t;

  ifs_pkg::cfg_t cfg_r;
  reg_idx_t      idx;
  logic          wr;

  assign idx     = reg_idx_t'(paddr[4:2]);
  assign wr      = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign cfg     = cfg_r;
  assign restart = wr && (idx == REG_COLS || idx == REG_ROWS);

  // Write registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.grid_columns <= 9'd256;
      cfg_r.grid_rows    <= 16'd256;
      cfg_r.inv_two_beta <= 31'd65536;
      cfg_r.inv_re_dx    <= 31'd65536;
      cfg_r.inv_re_dy    <= 31'd65536;
      cfg_r.inv_dx       <= 31'd65536;
      cfg_r.inv_dy       <= 31'd65536;
    end else if (wr) begin
      unique case (idx)
        REG_COLS: cfg_r.grid_columns <= pwdata[8:0];
        REG_ROWS: cfg_r.grid_rows    <= pwdata[15:0];
        REG_I2B:  cfg_r.inv_two_beta <= pwdata[30:0];
        REG_IRX:  cfg_r.inv_re_dx    <= pwdata[30:0];
        REG_IRY:  cfg_r.inv_re_dy    <= pwdata[30:0];
        REG_IDX:  cfg_r.inv_dx       <= pwdata[30:0];
        REG_IDY:  cfg_r.inv_dy       <= pwdata[30:0];
        REG_NONE: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (idx)
      REG_COLS: prdata = 32'(cfg_r.grid_columns);
      REG_ROWS: prdata = 32'(cfg_r.grid_rows);
      REG_I2B:  prdata = 32'(cfg_r.inv_two_beta);
      REG_IRX:  prdata = 32'(cfg_r.inv_re_dx);
      REG_IRY:  prdata = 32'(cfg_r.inv_re_dy);
      REG_IDX:  prdata = 32'(cfg_r.inv_dx);
      REG_IDY:  prdata = 32'(cfg_r.inv_dy);
      REG_NONE: prdata = '0;
    endcase
  end

endmodule

// ----- src/ifs_dp.sv -----
// ----------------------------------------------------------------------------
// ifs_dp: stencil datapath
// Row stores, three-cell window, raster counters, a bit-serial multiplier with
// rounding and saturation, the flux accumulators and the result register.
// ----------------------------------------------------------------------------
module ifs_dp (
  input  logic              clk,
  input  logic              rst_n,
  input  ifs_pkg::cmd_t     cmd,
  input  ifs_pkg::cfg_t     cfg,
  input  logic              restart,
  input  ifs_pkg::cell_t    in_cell,
  output ifs_pkg::sts_t     sts,
  output ifs_pkg::res_t     res
);

  localparam int COL_W = ifs_pkg::COL_W;
  localparam int CW    = ifs_pkg::CW;
  localparam int PW    = ifs_pkg::PW;
  localparam int F     = ifs_pkg::FRAC_BITS;
  localparam logic [PW-1:0] LIM_W = PW'(ifs_pkg::LIM);

  ifs_pkg::cell_t bank_a [ifs_pkg::MAX_COLUMNS];
  ifs_pkg::cell_t bank_b [ifs_pkg::MAX_COLUMNS];

  ifs_pkg::cell_t in_r, win0_r, win1_r, win2_r, old_r, new0_r;
  ifs_pkg::cell_t rd_a_q_r, rd_b_q_r, newer_q, older_q;
  logic [COL_W-1:0] col_r, na, addr_a, addr_b;
  logic [15:0]      row_r;
  logic             bank_sel_r;
  logic [CW-1:0]    c_eff, col1, col2;
  logic [15:0]      r_eff;
  logic [16:0]      row1;
  logic             interior;

  logic [COL_W-1:0] m_col_r;
  logic [15:0]      m_row_r;
  logic             m_last_r;

  logic signed [63:0] opv [ifs_pkg::OP_COUNT];
  ifs_pkg::step_t     st;
  logic signed [63:0] a_val, b_val, a_mag, b_mag;
  logic [PW-1:0]      ma_r, prod_r, qf;
  logic [ifs_pkg::MB_W-1:0] mb_r;
  logic               neg_r;
  logic signed [63:0] qmag, q, q_r, term, acc_nxt, acc_r;
  logic signed [63:0] dfm_r, dgm_r, dfx_r, dfy_r, dgx_r, dgy_r, fm_r, fx_r, fy_r;
  ifs_pkg::res_t      res_r;

  // Effective grid size
  always_comb begin
    if (32'(cfg.grid_columns) < 3)
      c_eff = CW'(3);
    else if (32'(cfg.grid_columns) > ifs_pkg::MAX_COLUMNS)
      c_eff = CW'(ifs_pkg::MAX_COLUMNS);
    else
      c_eff = CW'(cfg.grid_columns);
    r_eff = (cfg.grid_rows < 16'd3) ? 16'd3 : cfg.grid_rows;
  end

  assign col1     = CW'(col_r) + CW'(1);
  assign col2     = CW'(col_r) + CW'(2);
  assign row1     = 17'(row_r) + 17'd1;
  assign interior = (row_r >= 16'd2) && (col_r != '0) && (col2 <= c_eff);
  assign sts.interior = interior;

  // Row store addresses: newer row at the look-ahead column, older at this one
  assign na      = cmd.rd1 ? COL_W'(1) : ((col_r == '0) ? '0 : col1[COL_W-1:0]);
  assign addr_a  = bank_sel_r ? na : col_r;
  assign addr_b  = bank_sel_r ? col_r : na;
  assign newer_q = bank_sel_r ? rd_a_q_r : rd_b_q_r;
  assign older_q = bank_sel_r ? rd_b_q_r : rd_a_q_r;

  // Row stores: registered reads, the new cell written into the older row
  always_ff @(posedge clk) begin
    rd_a_q_r <= bank_a[addr_a];
    rd_b_q_r <= bank_b[addr_b];
    if (cmd.win && !bank_sel_r) begin
      bank_a[col_r] <= in_r;
    end
    if (cmd.win && bank_sel_r) begin
      bank_b[col_r] <= in_r;
    end
  end

  // Capture the input cell and the store read data
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      in_r <= in_cell;
    end
    if (cmd.rd1) begin
      new0_r <= newer_q;
      old_r  <= older_q;
    end
    if (cmd.win) begin
      m_col_r  <= col_r;
      m_row_r  <= row_r - 16'd1;
      m_last_r <= (row1 == 17'(r_eff)) && (col2 == c_eff);
    end
  end

  // Shift the window and advance the raster counters
  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      col_r  <= '0;
      row_r  <= '0;
      win0_r <= '0;
      win1_r <= '0;
      win2_r <= '0;
      if (!rst_n) begin
        bank_sel_r <= 1'b0;
      end
    end else if (cmd.win) begin
      if (col_r == '0) begin
        win0_r <= '0;
        win1_r <= new0_r;
        win2_r <= newer_q;
      end else begin
        win0_r <= win1_r;
        win1_r <= win2_r;
        win2_r <= (col1 < c_eff) ? new0_r : '0;
      end
      if (col1 >= c_eff) begin
        col_r      <= '0;
        bank_sel_r <= !bank_sel_r;
        row_r      <= (row1 >= 17'(r_eff)) ? '0 : row1[15:0];
      end else begin
        col_r <= col1[COL_W-1:0];
      end
    end
  end

  // Operand sources; after the window update win0/win1/win2 are west/centre/east
  always_comb begin
    opv[ifs_pkg::OP_DUEW] = ifs_pkg::ext(win2_r.u) - ifs_pkg::ext(win0_r.u);
    opv[ifs_pkg::OP_DVNS] = ifs_pkg::ext(in_r.v) - ifs_pkg::ext(old_r.v);
    opv[ifs_pkg::OP_SUE]  = ifs_pkg::ext(win2_r.u) + ifs_pkg::ext(win1_r.u);
    opv[ifs_pkg::OP_SUW]  = ifs_pkg::ext(win1_r.u) + ifs_pkg::ext(win0_r.u);
    opv[ifs_pkg::OP_SVE]  = ifs_pkg::ext(win2_r.v) + ifs_pkg::ext(win1_r.v);
    opv[ifs_pkg::OP_SVW]  = ifs_pkg::ext(win1_r.v) + ifs_pkg::ext(win0_r.v);
    opv[ifs_pkg::OP_SUN]  = ifs_pkg::ext(in_r.u) + ifs_pkg::ext(win1_r.u);
    opv[ifs_pkg::OP_SUS]  = ifs_pkg::ext(win1_r.u) + ifs_pkg::ext(old_r.u);
    opv[ifs_pkg::OP_SVN]  = ifs_pkg::ext(in_r.v) + ifs_pkg::ext(win1_r.v);
    opv[ifs_pkg::OP_SVS]  = ifs_pkg::ext(win1_r.v) + ifs_pkg::ext(old_r.v);
    opv[ifs_pkg::OP_DPEW] = ifs_pkg::ext(win2_r.p) - ifs_pkg::ext(win0_r.p);
    opv[ifs_pkg::OP_DPNS] = ifs_pkg::ext(in_r.p) - ifs_pkg::ext(old_r.p);
    opv[ifs_pkg::OP_LUX]  = ifs_pkg::ext(win2_r.u) - (ifs_pkg::ext(win1_r.u) <<< 1)
                            + ifs_pkg::ext(win0_r.u);
    opv[ifs_pkg::OP_LVX]  = ifs_pkg::ext(win2_r.v) - (ifs_pkg::ext(win1_r.v) <<< 1)
                            + ifs_pkg::ext(win0_r.v);
    opv[ifs_pkg::OP_LUY]  = ifs_pkg::ext(in_r.u) - (ifs_pkg::ext(win1_r.u) <<< 1)
                            + ifs_pkg::ext(old_r.u);
    opv[ifs_pkg::OP_LVY]  = ifs_pkg::ext(in_r.v) - (ifs_pkg::ext(win1_r.v) <<< 1)
                            + ifs_pkg::ext(old_r.v);
    opv[ifs_pkg::OP_DFM]  = dfm_r;
    opv[ifs_pkg::OP_DGM]  = dgm_r;
    opv[ifs_pkg::OP_DFX]  = dfx_r;
    opv[ifs_pkg::OP_DFY]  = dfy_r;
    opv[ifs_pkg::OP_DGX]  = dgx_r;
    opv[ifs_pkg::OP_DGY]  = dgy_r;
    opv[ifs_pkg::OP_I2B]  = 64'(cfg.inv_two_beta);
    opv[ifs_pkg::OP_IRX]  = 64'(cfg.inv_re_dx);
    opv[ifs_pkg::OP_IRY]  = 64'(cfg.inv_re_dy);
    opv[ifs_pkg::OP_IDX]  = 64'(cfg.inv_dx);
    opv[ifs_pkg::OP_IDY]  = 64'(cfg.inv_dy);
    opv[ifs_pkg::OP_ONE]  = 64'sd1;
  end

  assign st    = ifs_pkg::step_info(cmd.step);
  assign a_val = opv[st.a];
  assign b_val = opv[st.b];
  assign a_mag = a_val[63] ? -a_val : a_val;
  assign b_mag = b_val[63] ? -b_val : b_val;
  assign sts.mul_done = (mb_r == '0);

  // Round half away from zero, shift, saturate the magnitude, apply the sign
  always_comb begin
    unique case (st.sh)
      ifs_pkg::SH_ONE: qf = (prod_r + PW'(1)) >> 1;
      ifs_pkg::SH_F:   qf = (prod_r + (PW'(1) << (F - 1))) >> F;
      ifs_pkg::SH_F2:  qf = (prod_r + (PW'(1) << (F + 1))) >> (F + 2);
      default:         qf = '0;
    endcase
    qmag = (qf > LIM_W) ? ifs_pkg::LIM : qf[63:0];
    q    = neg_r ? -qmag : qmag;
  end

  assign term    = st.sub ? -q_r : q_r;
  assign acc_nxt = st.first ? term : ifs_pkg::sat61(acc_r + term);

  // Bit-serial multiply, then round and accumulate
  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      ma_r   <= PW'(a_mag[ifs_pkg::MA_W-1:0]);
      mb_r   <= b_mag[ifs_pkg::MB_W-1:0];
      prod_r <= '0;
      neg_r  <= a_val[63] ^ b_val[63];
    end else if (cmd.run) begin
      if (mb_r[0]) begin
        prod_r <= prod_r + ma_r;
      end
      ma_r <= ma_r << 1;
      mb_r <= mb_r >> 1;
    end
    if (cmd.rnd) begin
      q_r <= q;
    end
    if (cmd.acc) begin
      acc_r <= acc_nxt;
      if (st.last) begin
        unique case (st.dest)
          ifs_pkg::D_DFM: dfm_r <= acc_nxt;
          ifs_pkg::D_DGM: dgm_r <= acc_nxt;
          ifs_pkg::D_DFX: dfx_r <= acc_nxt;
          ifs_pkg::D_DFY: dfy_r <= acc_nxt;
          ifs_pkg::D_DGX: dgx_r <= acc_nxt;
          ifs_pkg::D_DGY: dgy_r <= acc_nxt;
          ifs_pkg::D_FM:  fm_r  <= acc_nxt;
          ifs_pkg::D_FX:  fx_r  <= acc_nxt;
          ifs_pkg::D_FY:  fy_r  <= acc_nxt;
          default: ;
        endcase
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      res_r.flux_mass       <= ifs_pkg::out32(fm_r);
      res_r.flux_x_momentum <= ifs_pkg::out32(fx_r);
      res_r.flux_y_momentum <= ifs_pkg::out32(fy_r);
      res_r.cell_column     <= 8'(m_col_r);
      res_r.cell_row        <= m_row_r;
      res_r.last_cell       <= m_last_r;
    end
  end

  assign res = res_r;

endmodule

// ----- src/ifs_ctrl.sv -----
// ----------------------------------------------------------------------------
// ifs_ctrl: stencil controller
// Sequences store reads, the window update and the 22 multiply-accumulate
// steps of an interior cell, and holds the result valid flag.
// ----------------------------------------------------------------------------
module ifs_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  ifs_pkg::sts_t sts,
  output ifs_pkg::cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_RD0, S_RD1, S_WIN, S_SETUP, S_RUN, S_RND, S_ACC, S_EMIT
  } state_t;

  state_t                     state_r;
  logic [ifs_pkg::STEP_W-1:0] step_r;
  logic                       out_valid_r;

  // Commands decoded from the state
  always_comb begin
    cmd       = '0;
    cmd.take  = (state_r == S_IDLE) && in_valid;
    cmd.rd0   = (state_r == S_RD0);
    cmd.rd1   = (state_r == S_RD1);
    cmd.win   = (state_r == S_WIN);
    cmd.setup = (state_r == S_SETUP);
    cmd.run   = (state_r == S_RUN);
    cmd.rnd   = (state_r == S_RND);
    cmd.acc   = (state_r == S_ACC);
    cmd.emit  = (state_r == S_EMIT) && (!out_valid_r || out_ready);
    cmd.step  = step_r;
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  // State, step counter and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: if (in_valid) state_r <= S_RD0;
        S_RD0:  state_r <= S_RD1;
        S_RD1:  state_r <= S_WIN;
        S_WIN: begin
          step_r  <= '0;
          state_r <= sts.interior ? S_SETUP : S_IDLE;
        end
        S_SETUP: state_r <= S_RUN;
        S_RUN:   if (sts.mul_done) state_r <= S_RND;
        S_RND:   state_r <= S_ACC;
        S_ACC: begin
          if (step_r == ifs_pkg::STEP_W'(ifs_pkg::LAST_STEP)) begin
            state_r <= S_EMIT;
          end else begin
            step_r  <= step_r + 1'b1;
            state_r <= S_SETUP;
          end
        end
        S_EMIT: if (cmd.emit) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    step_r <= ifs_pkg::STEP_W'(ifs_pkg::LAST_STEP))
    else $error("step counter past last step");

  a_last_emits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ACC && step_r == ifs_pkg::STEP_W'(ifs_pkg::LAST_STEP))
    |=> state_r == S_EMIT)
    else $error("last step did not lead to result");

  a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> out_valid_r)
    else $error("loaded result not marked valid");

  a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !cmd.take)
    else $error("cell taken while busy");

endmodule

// ----- src/incompressible_flux_stencil.sv -----
// ----------------------------------------------------------------------------
// incompressible_flux_stencil: 5-point flux integral stencil
// Streams raster-ordered cells and returns flux integrals of interior cells.
//
//   channel  direction  handshake        payload
//   in_ch    sink       valid / ready    pressure, u_velocity, v_velocity
//   out_ch   source     valid / ready    three fluxes, cell_column, cell_row,
//                                        last_cell
//   cfg_*    slave      APB psel/penable seven registers at 4*index
//
// Every cell passes through accept, two row store reads and the window update.
// An interior cell adds 22 multiply-accumulate steps on one shared bit-serial
// multiplier, each a setup, a shift-add run over the significant multiplier
// bits (up to 33), rounding and accumulation, and then loads the result
// register.
// Reset (rst_n low, synchronous) clears the counters, window and result valid.
// The next cell is accepted while a finished result waits on out_ch.
// ----------------------------------------------------------------------------
module incompressible_flux_stencil (
  input  logic                         clk,
  input  logic                         rst_n,
  ifs_in_if.sink                       in_ch,
  ifs_out_if.source                    out_ch,
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [ifs_pkg::ADDR_W-1:0]   cfg_paddr,
  input  logic [ifs_pkg::DATA_W-1:0]   cfg_pwdata,
  output logic [ifs_pkg::DATA_W-1:0]   cfg_prdata,
  output logic                         cfg_pready
);

  ifs_pkg::cfg_t  cfg;
  ifs_pkg::cmd_t  cmd;
  ifs_pkg::sts_t  sts;
  ifs_pkg::cell_t in_cell;
  ifs_pkg::res_t  res;
  logic           restart;

  assign in_cell.p = in_ch.pressure;
  assign in_cell.u = in_ch.u_velocity;
  assign in_cell.v = in_ch.v_velocity;

  ifs_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg),
    .restart (restart)
  );

  ifs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ifs_dp u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .cfg     (cfg),
    .restart (restart),
    .in_cell (in_cell),
    .sts     (sts),
    .res     (res)
  );

  // Drive the result channel payload
  assign out_ch.flux_mass       = res.flux_mass;
  assign out_ch.flux_x_momentum = res.flux_x_momentum;
  assign out_ch.flux_y_momentum = res.flux_y_momentum;
  assign out_ch.cell_column     = res.cell_column;
  assign out_ch.cell_row        = res.cell_row;
  assign out_ch.last_cell       = res.last_cell;

endmodule
